// ----- hw/rtl/qte_pkg.sv -----
// qte_pkg: shared constants, tables and types for the quaternion to Euler block.
// No dependencies; every other file of the block imports it.
package qte_pkg;

  localparam int unsigned CORDIC_STAGES_DEF  = 16;
  localparam int unsigned COMPONENT_BITS_DEF = 16;

  localparam int unsigned ANGLE_BITS    = 16;
  localparam int unsigned NORM_BITS     = 30;   // normalized operands lie below 2^30
  localparam int unsigned CX_BITS       = 33;   // CORDIC x/y datapath, signed
  localparam int unsigned Z_BITS        = 33;   // CORDIC angle accumulator, signed
  localparam int unsigned RES_BITS      = 34;   // full-scale angle, 2^31 = pi
  localparam int unsigned SQ_ROOT_BITS  = 31;
  localparam int unsigned SQ_RAD_BITS   = 61;
  localparam int unsigned ATAN_TAB_SIZE = 32;

  localparam logic signed [RES_BITS-1:0] ANG_HALF_PI = RES_BITS'(64'sd1073741824);
  localparam logic signed [RES_BITS-1:0] ANG_PI      = RES_BITS'(64'sd2147483648);

  // atan(2^-i) with 2^31 = pi
  localparam logic [NORM_BITS-1:0] ATAN_TAB [ATAN_TAB_SIZE] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  // operand classification carried alongside a CORDIC lane
  typedef struct packed {
    logic both_zero;
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
  } atan_flags_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] yaw_angle;
    logic [ANGLE_BITS-1:0] pitch_angle;
    logic [ANGLE_BITS-1:0] roll_angle;
    logic                  zero_input;
  } euler_t;

endpackage

// ----- hw/rtl/qte_if.sv -----
// qte_if: valid/ready channel interfaces for quaternions in and Euler angles out.
// Depends on qte_pkg.
interface qte_quat_if import qte_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = COMPONENT_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] quat_w;
  logic signed [COMPONENT_BITS-1:0] quat_x;
  logic signed [COMPONENT_BITS-1:0] quat_y;
  logic signed [COMPONENT_BITS-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if import qte_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] yaw_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic                         zero_input;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, zero_input,
                  input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, zero_input,
                  output ready);
endinterface

// ----- hw/rtl/qte_delay.sv -----
// qte_delay: enabled shift line that keeps side data aligned with the pipeline.
// Depends on qte_pkg.
module qte_delay import qte_pkg::*; #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];
endmodule

// ----- hw/rtl/qte_norm.sv -----
// qte_norm: joint normalization of two magnitudes so the larger lies in [2^29, 2^30).
// Two stages: leading-one search, then shift. Depends on qte_pkg.
module qte_norm import qte_pkg::*; #(
  parameter int unsigned IW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [IW-1:0]        a,
  input  logic [IW-1:0]        b,
  output logic [NORM_BITS-1:0] na,
  output logic [NORM_BITS-1:0] nb
);
  localparam int unsigned PB = $clog2(IW + 1) + 1;
  localparam int unsigned EW = (IW > NORM_BITS) ? IW : NORM_BITS;
  localparam logic [PB-1:0] TOP = PB'(NORM_BITS - 1);

  logic [IW-1:0] m;
  logic [PB-1:0] p;
  logic [IW-1:0] a_q, b_q;
  logic [PB-1:0] p_q;
  logic [EW-1:0] ea, eb, sa, sb;

  always_comb begin
    m = (a > b) ? a : b;
    p = '0;
    for (int i = 0; i < IW; i++) begin
      if (m[i]) p = PB'(i);
    end
  end

  always_comb begin
    ea = EW'(a_q);
    eb = EW'(b_q);
    if (p_q >= TOP) begin
      sa = ea >> (p_q - TOP);
      sb = eb >> (p_q - TOP);
    end else begin
      sa = ea << (TOP - p_q);
      sb = eb << (TOP - p_q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q <= a;
      b_q <= b;
      p_q <= p;
      na  <= sa[NORM_BITS-1:0];
      nb  <= sb[NORM_BITS-1:0];
    end
  end
endmodule

// ----- hw/rtl/qte_sqrt_cell.sv -----
// qte_sqrt_cell: one digit of a restoring integer square root; decides root bit B.
// Depends on qte_pkg.
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int unsigned B = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [SQ_RAD_BITS-1:0]  rem_in,
  input  logic [SQ_ROOT_BITS-1:0] root_in,
  output logic [SQ_RAD_BITS-1:0]  rem_out,
  output logic [SQ_ROOT_BITS-1:0] root_out
);
  localparam int unsigned TW = SQ_RAD_BITS + 2;

  logic [TW-1:0] trial;
  logic          take;

  // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
  assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
  assign take  = TW'(rem_in) >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? rem_in - trial[SQ_RAD_BITS-1:0] : rem_in;
      root_out <= take ? (root_in | (SQ_ROOT_BITS'(1) << B)) : root_in;
    end
  end
endmodule

// ----- hw/rtl/qte_cordic_cell.sv -----
// qte_cordic_cell: one vectoring CORDIC micro-rotation, step I, registered.
// Depends on qte_pkg (atan table).
module qte_cordic_cell import qte_pkg::*; #(
  parameter int unsigned I = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [CX_BITS-1:0] cx_in,
  input  logic signed [CX_BITS-1:0] cy_in,
  input  logic signed [Z_BITS-1:0]  z_in,
  output logic signed [CX_BITS-1:0] cx_out,
  output logic signed [CX_BITS-1:0] cy_out,
  output logic signed [Z_BITS-1:0]  z_out
);
  logic signed [Z_BITS-1:0] step;

  assign step = $signed(Z_BITS'(ATAN_TAB[I]));

  always_ff @(posedge clk) begin
    if (en) begin
      if (cy_in >= 0) begin
        cx_out <= cx_in + (cy_in >>> I);
        cy_out <= cy_in - (cx_in >>> I);
        z_out  <= z_in + step;
      end else begin
        cx_out <= cx_in - (cy_in >>> I);
        cy_out <= cy_in + (cx_in >>> I);
        z_out  <= z_in - step;
      end
    end
  end
endmodule

// ----- hw/rtl/qte_atan2.sv -----
// qte_atan2: pipelined atan2 lane: classify, normalize, CORDIC cell chain, finish.
// Depends on qte_pkg, qte_delay, qte_norm, qte_cordic_cell.
module qte_atan2 import qte_pkg::*; #(
  parameter int unsigned IW     = 32,
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [IW-1:0]         y,
  input  logic signed [IW-1:0]         x,
  output logic        [ANGLE_BITS-1:0] angle
);
  logic [IW-1:0]            ax, ay;
  atan_flags_t              fl_q, fl_end;
  logic [NORM_BITS-1:0]     na, nb;
  logic signed [CX_BITS-1:0] cx [STAGES+1];
  logic signed [CX_BITS-1:0] cy [STAGES+1];
  logic signed [Z_BITS-1:0]  zz [STAGES+1];
  logic [NORM_BITS:0]        zc;
  logic signed [RES_BITS-1:0] full, res;
  logic signed [RES_BITS:0]   rnd;

  always_ff @(posedge clk) begin
    if (en) begin
      ax             <= x[IW-1] ? IW'(-x) : IW'(x);
      ay             <= y[IW-1] ? IW'(-y) : IW'(y);
      fl_q.x_zero    <= (x == '0);
      fl_q.y_zero    <= (y == '0);
      fl_q.both_zero <= (x == '0) && (y == '0);
      fl_q.x_neg     <= x[IW-1];
      fl_q.y_neg     <= y[IW-1];
    end
  end

  qte_norm #(.IW(IW)) u_norm (
    .clk(clk), .en(en), .a(ax), .b(ay), .na(na), .nb(nb)
  );

  qte_delay #(.W($bits(atan_flags_t)), .DEPTH(STAGES + 2)) u_fl (
    .clk(clk), .en(en), .d(fl_q), .q(fl_end)
  );

  assign cx[0] = $signed(CX_BITS'(na));
  assign cy[0] = $signed(CX_BITS'(nb));
  assign zz[0] = '0;

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    qte_cordic_cell #(.I(g)) u_cell (
      .clk(clk), .en(en),
      .cx_in(cx[g]), .cy_in(cy[g]), .z_in(zz[g]),
      .cx_out(cx[g+1]), .cy_out(cy[g+1]), .z_out(zz[g+1])
    );
  end

  always_comb begin
    if (zz[STAGES] < 0) begin
      zc = '0;
    end else if (zz[STAGES] > Z_BITS'(ANG_HALF_PI)) begin
      zc = (NORM_BITS+1)'(ANG_HALF_PI);
    end else begin
      zc = zz[STAGES][NORM_BITS:0];
    end
    full = fl_end.x_neg ? ANG_PI - $signed(RES_BITS'(zc)) : $signed(RES_BITS'(zc));
    res  = fl_end.y_neg ? -full : full;
    if (fl_end.both_zero) begin
      res = '0;
    end else if (fl_end.x_zero) begin
      res = fl_end.y_neg ? -ANG_HALF_PI : ANG_HALF_PI;
    end else if (fl_end.y_zero) begin
      res = fl_end.x_neg ? ANG_PI : '0;
    end
    rnd = (RES_BITS+1)'(res) + (RES_BITS+1)'(32768);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= rnd[ANGLE_BITS+15:16];
    end
  end
endmodule

// ----- hw/rtl/quaternion_to_euler_zyx.sv -----
// quaternion_to_euler_zyx: top level, quaternion in, ZYX Euler angles out.
// Depends on qte_pkg, qte_if, qte_delay, qte_norm, qte_sqrt_cell, qte_atan2.
//
// Takes one quaternion (w,x,y,z), signed fixed point that need not be unit
// length, per transfer and returns yaw, pitch and roll in binary angle units
// (32768 = pi). Fully pipelined: a new quaternion is accepted every clock
// while the output buffer has room. The chain is: input register, the ten
// products, sums, joint normalization for pitch (2), difference/sum and
// product (2), a 31-cell square root, then three parallel atan2 lanes of
// CORDIC_STAGES cells plus classify, normalize and finish, and a two-entry
// output buffer. Pitch is atan2(2(wy-xz), sqrt(n^2 - s^2)) so no divider is
// needed. An all-zero quaternion sets zero_input and gives zero angles.
// Backpressure stalls the whole pipeline only once the output buffer holds
// two results.
module quaternion_to_euler_zyx import qte_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int unsigned CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
  input logic         clk,
  input logic         rst,
  qte_quat_if.sink    quat_in,
  qte_euler_if.source euler_out
);
  localparam int unsigned CB   = COMPONENT_BITS;
  localparam int unsigned PW   = (CB > 31) ? 62 : 2 * CB;       // scaled product width
  localparam int unsigned SH   = (CB > 31) ? 2 * CB - 62 : 0;   // product pre-shift
  localparam int unsigned SW   = PW + 2;                        // sums
  localparam int unsigned AW   = (SW > 32) ? SW : 32;           // atan2 operand width
  localparam int unsigned LAT_PITCH = 4 + SQ_ROOT_BITS;         // sums -> atan2 inputs
  localparam int unsigned LA   = CORDIC_STAGES + 4;             // atan2 lane latency
  localparam int unsigned D    = 3 + LAT_PITCH + LA;            // valid chain depth

  logic en;
  logic [D-1:0] vld;

  // stage 0: input register
  logic signed [CB-1:0] w0, x0, y0, z0;
  always_ff @(posedge clk) begin
    if (en) begin
      w0 <= quat_in.quat_w;
      x0 <= quat_in.quat_x;
      y0 <= quat_in.quat_y;
      z0 <= quat_in.quat_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-2:0], quat_in.valid};
    end
  end

  assign quat_in.ready = en;

  // stage 1: ten products, one multiplier each, registered
  logic signed [2*CB-1:0] m_ww, m_xx, m_yy, m_zz, m_xy, m_wz, m_xz, m_wy, m_yz, m_wx;
  logic signed [2*CB-1:0] s_ww, s_xx, s_yy, s_zz, s_xy, s_wz, s_xz, s_wy, s_yz, s_wx;
  logic signed [PW-1:0]   ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic                   zf1;

  assign m_ww = w0 * w0;  assign m_xx = x0 * x0;
  assign m_yy = y0 * y0;  assign m_zz = z0 * z0;
  assign m_xy = x0 * y0;  assign m_wz = w0 * z0;
  assign m_xz = x0 * z0;  assign m_wy = w0 * y0;
  assign m_yz = y0 * z0;  assign m_wx = w0 * x0;

  assign s_ww = m_ww >>> SH;  assign s_xx = m_xx >>> SH;
  assign s_yy = m_yy >>> SH;  assign s_zz = m_zz >>> SH;
  assign s_xy = m_xy >>> SH;  assign s_wz = m_wz >>> SH;
  assign s_xz = m_xz >>> SH;  assign s_wy = m_wy >>> SH;
  assign s_yz = m_yz >>> SH;  assign s_wx = m_wx >>> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      ww  <= s_ww[PW-1:0];  xx <= s_xx[PW-1:0];
      yy  <= s_yy[PW-1:0];  zz <= s_zz[PW-1:0];
      xy  <= s_xy[PW-1:0];  wz <= s_wz[PW-1:0];
      xz  <= s_xz[PW-1:0];  wy <= s_wy[PW-1:0];
      yz  <= s_yz[PW-1:0];  wx <= s_wx[PW-1:0];
      zf1 <= (w0 == '0) && (x0 == '0) && (y0 == '0) && (z0 == '0);
    end
  end

  // stage 2: numerators, denominators, asin numerator s and squared norm n
  logic signed [SW-1:0] ny, dy, nr, dr, ss, nn;
  always_ff @(posedge clk) begin
    if (en) begin
      ny <= (SW'(xy) + SW'(wz)) <<< 1;
      dy <= SW'(ww) + SW'(xx) - SW'(yy) - SW'(zz);
      nr <= (SW'(yz) + SW'(wx)) <<< 1;
      dr <= SW'(ww) - SW'(xx) - SW'(yy) + SW'(zz);
      ss <= (SW'(wy) - SW'(xz)) <<< 1;
      nn <= SW'(ww) + SW'(xx) + SW'(yy) + SW'(zz);
    end
  end

  // pitch path: normalize (n, |s|) together
  logic [SW-1:0]        s_mag, n_pos;
  logic [NORM_BITS-1:0] un_n, as_n;
  logic                 s_neg_n;

  assign s_mag = ss[SW-1] ? SW'(-ss) : SW'(ss);
  assign n_pos = nn[SW-1] ? '0 : SW'(nn);

  qte_norm #(.IW(SW)) u_pnorm (
    .clk(clk), .en(en), .a(n_pos), .b(s_mag), .na(un_n), .nb(as_n)
  );

  qte_delay #(.W(1), .DEPTH(2)) u_ssign (
    .clk(clk), .en(en), .d(ss[SW-1]), .q(s_neg_n)
  );

  // (n-|s|)(n+|s|), only meaningful when n > |s|
  logic [NORM_BITS-1:0]   dd, as3;
  logic [NORM_BITS:0]     ee;
  logic                   gt3, sneg3;
  logic [SQ_RAD_BITS-1:0] rad;
  logic                   gt4, sneg4;
  logic [NORM_BITS-1:0]   as4;

  always_ff @(posedge clk) begin
    if (en) begin
      gt3   <= un_n > as_n;
      dd    <= un_n - as_n;
      ee    <= (NORM_BITS+1)'(un_n) + (NORM_BITS+1)'(as_n);
      as3   <= as_n;
      sneg3 <= s_neg_n;
      rad   <= SQ_RAD_BITS'(dd) * SQ_RAD_BITS'(ee);
      gt4   <= gt3;
      sneg4 <= sneg3;
      as4   <= as3;
    end
  end

  // square root: one cell per root bit, most significant first
  logic [SQ_RAD_BITS-1:0]  rem_c  [SQ_ROOT_BITS+1];
  logic [SQ_ROOT_BITS-1:0] root_c [SQ_ROOT_BITS+1];

  assign rem_c[0]  = rad;
  assign root_c[0] = '0;

  for (genvar k = 0; k < SQ_ROOT_BITS; k++) begin : g_sqrt
    qte_sqrt_cell #(.B(SQ_ROOT_BITS - 1 - k)) u_cell (
      .clk(clk), .en(en),
      .rem_in(rem_c[k]), .root_in(root_c[k]),
      .rem_out(rem_c[k+1]), .root_out(root_c[k+1])
    );
  end

  logic                 gt_e, sneg_e;
  logic [NORM_BITS-1:0] as_e;
  qte_delay #(.W(NORM_BITS + 2), .DEPTH(SQ_ROOT_BITS)) u_pside (
    .clk(clk), .en(en), .d({gt4, sneg4, as4}), .q({gt_e, sneg_e, as_e})
  );

  logic signed [AW-1:0] p_y, p_x;
  assign p_y = sneg_e ? -$signed(AW'(as_e)) : $signed(AW'(as_e));
  assign p_x = gt_e ? $signed(AW'(root_c[SQ_ROOT_BITS])) : '0;

  // yaw and roll operands wait for the pitch path
  logic signed [SW-1:0] ny_e, dy_e, nr_e, dr_e;
  qte_delay #(.W(4 * SW), .DEPTH(LAT_PITCH)) u_yr (
    .clk(clk), .en(en), .d({ny, dy, nr, dr}), .q({ny_e, dy_e, nr_e, dr_e})
  );

  logic [ANGLE_BITS-1:0] yaw_a, pitch_a, roll_a;

  qte_atan2 #(.IW(AW), .STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .y(AW'(ny_e)), .x(AW'(dy_e)), .angle(yaw_a)
  );
  qte_atan2 #(.IW(AW), .STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .y(p_y), .x(p_x), .angle(pitch_a)
  );
  qte_atan2 #(.IW(AW), .STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .y(AW'(nr_e)), .x(AW'(dr_e)), .angle(roll_a)
  );

  logic zf_e;
  qte_delay #(.W(1), .DEPTH(D - 2)) u_zf (
    .clk(clk), .en(en), .d(zf1), .q(zf_e)
  );

  euler_t res;
  always_comb begin
    res.zero_input  = zf_e;
    res.yaw_angle   = zf_e ? '0 : yaw_a;
    res.pitch_angle = zf_e ? '0 : pitch_a;
    res.roll_angle  = zf_e ? '0 : roll_a;
  end

  // two-entry output buffer; the pipeline runs while it has room
  euler_t     buf_q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt;
  logic       push, pop;

  assign en   = (cnt != 2'd2);
  assign push = en && vld[D-1];
  assign pop  = euler_out.valid && euler_out.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assign euler_out.valid       = (cnt != 2'd0);
  assign euler_out.yaw_angle   = buf_q[rd_ptr].yaw_angle;
  assign euler_out.pitch_angle = buf_q[rd_ptr].pitch_angle;
  assign euler_out.roll_angle  = buf_q[rd_ptr].roll_angle;
  assign euler_out.zero_input  = buf_q[rd_ptr].zero_input;

  // zero quaternion must come out with all angles zero
  a_zero_angles: assert property (@(posedge clk) disable iff (rst)
    euler_out.valid && euler_out.zero_input |->
      euler_out.yaw_angle == '0 && euler_out.pitch_angle == '0 &&
      euler_out.roll_angle == '0)
    else $error("zero quaternion with nonzero angle");

  // pitch stays within plus or minus half pi
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    euler_out.valid |->
      euler_out.pitch_angle >= -16'sd16384 && euler_out.pitch_angle <= 16'sd16384)
    else $error("pitch out of range");

  // a stalled pipeline keeps its valid chain
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid chain moved during stall");

  // buffer count never exceeds two entries
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("output buffer overflow");
endmodule
